>>> hdl/pfdm_pkg.sv
`default_nettype none
package pfdm_pkg;

	// Capture counter ticks per divided clock period
	localparam int unsigned CYCLES_PER_COUNT = 2;

	// Field widths
	localparam int unsigned COUNT_W = 32;
	localparam int unsigned SYSCLK_W = 28;
	localparam int unsigned CLKDIV_W = 16;
	localparam int unsigned FREQ_W = 31;
	localparam int unsigned DUTY_W = 10;
	localparam int unsigned CFG_DATA_W = 28;

	// Duty scale: full duty in tenths of a percent
	localparam logic [DUTY_W-1:0] DUTY_FULL = DUTY_W'(1000);

	// Serial multiplier operand: divider times ticks per count
	localparam int unsigned CPC_W = $clog2(CYCLES_PER_COUNT + 1);
	localparam int unsigned MUL_W = CLKDIV_W + CPC_W;

	// Divider widths: numerator up to count * 1000, denominator up to count * MUL
	localparam int unsigned NUM_W = COUNT_W + DUTY_W;
	localparam int unsigned DEN_W = COUNT_W + MUL_W;
	localparam int unsigned STEP_W = $clog2(NUM_W + 1);
	localparam int unsigned FREQ_NUM_W = 32;

	// Configuration register indexes
	typedef enum logic [0:0] {
		CFG_SYS_CLOCK_HZ = 1'b0,
		CFG_CLOCK_DIVIDER = 1'b1
	} cfg_index_t;

	// Edge kinds
	localparam logic KIND_RISE = 1'b0;
	localparam logic KIND_FALL = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_MUL,
		ST_DIV,
		ST_FIN
	} state_t;

	// Divider request and status
	typedef struct packed {
		logic start;
		logic [STEP_W-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage
`default_nettype wire

>>> hdl/pfdm_div.sv
`default_nettype none
module pfdm_div (
	input wire logic clk,
	input wire logic arst_n,
	input wire pfdm_pkg::div_req_t req,
	input wire logic [pfdm_pkg::NUM_W-1:0] num,
	input wire logic [pfdm_pkg::DEN_W-1:0] den,
	output pfdm_pkg::div_stat_t stat,
	output logic [pfdm_pkg::NUM_W-1:0] quo
);

	logic [pfdm_pkg::DEN_W-1:0] rem_q;
	logic [pfdm_pkg::DEN_W-1:0] den_q;
	logic [pfdm_pkg::NUM_W-1:0] num_q;
	logic [pfdm_pkg::NUM_W-1:0] quo_q;
	logic [pfdm_pkg::STEP_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [pfdm_pkg::DEN_W:0] trial;
	logic ge;

	// Shift the next numerator bit into the partial remainder and try a subtract
	assign trial = {rem_q, num_q[pfdm_pkg::NUM_W-1]};
	assign ge = (trial >= {1'b0, den_q});

	// Control: count quotient bits, flag the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == pfdm_pkg::STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: one restoring step per cycle
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			den_q <= den;
			num_q <= num;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? pfdm_pkg::DEN_W'(trial - {1'b0, den_q}) : trial[pfdm_pkg::DEN_W-1:0];
			num_q <= {num_q[pfdm_pkg::NUM_W-2:0], 1'b0};
			quo_q <= {quo_q[pfdm_pkg::NUM_W-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quo = quo_q;

endmodule
`default_nettype wire

>>> hdl/pwm_frequency_duty_meter_unit.sv
// Sequence: an accepted event passes PREP, MUL and DIV to FIN, where the result word is
// registered; a zero period or a saturated duty goes from PREP straight to FIN. MUL runs
// the shift-add multiplier one bit per cycle over its operand (clock_divider * ticks per
// count, or 10 bits for duty); DIV runs the restoring divider one quotient bit per cycle,
// 32 bits for a frequency or 42 for a duty. One event at a time; FIN waits on m_tready.
// Reset: asynchronous, active low; clears all held measurements and restores the registers.
`default_nettype none
module pwm_frequency_duty_meter_unit (
	input wire logic clk,
	input wire logic arst_n,
	// Event input
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [31:0] s_tdata, // [31:0] capture_count
	input wire logic s_tuser, // [0] edge_kind
	// Result output
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [79:0] m_tdata, // [31:0] count_echo, [62:32] frequency_decihz,
	// [72:63] duty_permille, [79:73] zero
	output logic [1:0] m_tuser, // [0] period_invalid, [1] duty_saturated
	// Configuration writes
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [0:0] cfg_index,
	input wire logic [pfdm_pkg::CFG_DATA_W-1:0] cfg_data
);

	pfdm_pkg::state_t state_q, state_d;

	logic [pfdm_pkg::SYSCLK_W-1:0] sys_clock_hz_q;
	logic [pfdm_pkg::CLKDIV_W-1:0] clock_divider_q;

	logic [pfdm_pkg::COUNT_W-1:0] last_rise_q;
	logic [pfdm_pkg::COUNT_W-1:0] period_q;
	logic [pfdm_pkg::FREQ_W-1:0] freq_q;
	logic [pfdm_pkg::DUTY_W-1:0] duty_q;

	logic [pfdm_pkg::COUNT_W-1:0] count_q;
	logic [pfdm_pkg::COUNT_W-1:0] diff_q;
	logic edge_q;
	logic sat_q;

	logic [pfdm_pkg::DEN_W-1:0] acc_q;
	logic [pfdm_pkg::DEN_W-1:0] mcand_q;
	logic [pfdm_pkg::MUL_W-1:0] mplier_q;

	logic [79:0] out_data_q;
	logic [1:0] out_user_q;
	logic out_valid_q;

	logic accept;
	logic out_free;
	logic [pfdm_pkg::CLKDIV_W-1:0] div_eff;
	logic [pfdm_pkg::MUL_W-1:0] mul_freq;
	logic [pfdm_pkg::FREQ_NUM_W-1:0] freq_num;

	pfdm_pkg::div_req_t div_req;
	pfdm_pkg::div_stat_t div_stat;
	logic [pfdm_pkg::NUM_W-1:0] div_num;
	logic [pfdm_pkg::DEN_W-1:0] div_den;
	logic [pfdm_pkg::NUM_W-1:0] div_quo;

	assign accept = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == pfdm_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;

	// A zero divider counts as one
	assign div_eff = (clock_divider_q == '0) ? pfdm_pkg::CLKDIV_W'(1) : clock_divider_q;
	assign mul_freq = pfdm_pkg::MUL_W'(div_eff) * pfdm_pkg::MUL_W'(pfdm_pkg::CYCLES_PER_COUNT);
	assign freq_num = pfdm_pkg::FREQ_NUM_W'(sys_clock_hz_q) * pfdm_pkg::FREQ_NUM_W'(10);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sys_clock_hz_q <= pfdm_pkg::SYSCLK_W'(133000000);
			clock_divider_q <= pfdm_pkg::CLKDIV_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (pfdm_pkg::cfg_index_t'(cfg_index))
				pfdm_pkg::CFG_SYS_CLOCK_HZ: sys_clock_hz_q <= cfg_data[pfdm_pkg::SYSCLK_W-1:0];
				pfdm_pkg::CFG_CLOCK_DIVIDER: clock_divider_q <= cfg_data[pfdm_pkg::CLKDIV_W-1:0];
			endcase
		end
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfdm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and divider launch
	always_comb begin
		state_d = state_q;
		div_req.start = 1'b0;
		div_req.steps = pfdm_pkg::STEP_W'(pfdm_pkg::NUM_W);
		div_num = acc_q[pfdm_pkg::NUM_W-1:0];
		div_den = pfdm_pkg::DEN_W'(period_q);
		if (edge_q == pfdm_pkg::KIND_RISE) begin
			div_req.steps = pfdm_pkg::STEP_W'(pfdm_pkg::FREQ_NUM_W);
			div_num = {freq_num, (pfdm_pkg::NUM_W - pfdm_pkg::FREQ_NUM_W)'(0)};
			div_den = acc_q;
		end
		unique case (state_q)
			pfdm_pkg::ST_IDLE: begin
				if (accept) state_d = pfdm_pkg::ST_PREP;
			end
			pfdm_pkg::ST_PREP: begin
				if (edge_q == pfdm_pkg::KIND_RISE) begin
					state_d = (diff_q == '0) ? pfdm_pkg::ST_FIN : pfdm_pkg::ST_MUL;
				end else if (period_q == '0 || diff_q > period_q) begin
					state_d = pfdm_pkg::ST_FIN;
				end else begin
					state_d = pfdm_pkg::ST_MUL;
				end
			end
			pfdm_pkg::ST_MUL: begin
				if (mplier_q == '0) begin
					div_req.start = 1'b1;
					state_d = pfdm_pkg::ST_DIV;
				end
			end
			pfdm_pkg::ST_DIV: begin
				if (div_stat.done) state_d = pfdm_pkg::ST_FIN;
			end
			pfdm_pkg::ST_FIN: begin
				if (out_free) state_d = pfdm_pkg::ST_IDLE;
			end
			default: state_d = pfdm_pkg::ST_IDLE;
		endcase
	end

	// Held measurement state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_rise_q <= '0;
			period_q <= '0;
			freq_q <= '0;
			duty_q <= '0;
		end else begin
			unique case (state_q)
				pfdm_pkg::ST_PREP: begin
					if (edge_q == pfdm_pkg::KIND_RISE) begin
						period_q <= diff_q;
						last_rise_q <= count_q;
						if (diff_q == '0) freq_q <= '0;
					end else if (period_q == '0) begin
						duty_q <= '0;
					end else if (diff_q > period_q) begin
						duty_q <= pfdm_pkg::DUTY_FULL;
					end
				end
				pfdm_pkg::ST_DIV: begin
					if (div_stat.done) begin
						if (edge_q == pfdm_pkg::KIND_RISE) begin
							freq_q <= div_quo[pfdm_pkg::FREQ_W-1:0];
						end else begin
							duty_q <= div_quo[pfdm_pkg::DUTY_W-1:0];
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Event capture and shift-add multiplier
	always_ff @(posedge clk) begin
		if (accept) begin
			count_q <= s_tdata;
			edge_q <= s_tuser;
			diff_q <= s_tdata - last_rise_q;
		end
		if (state_q == pfdm_pkg::ST_PREP) begin
			sat_q <= (edge_q == pfdm_pkg::KIND_FALL) && (period_q != '0) && (diff_q > period_q);
			acc_q <= '0;
			mcand_q <= pfdm_pkg::DEN_W'(diff_q);
			mplier_q <= (edge_q == pfdm_pkg::KIND_RISE) ? mul_freq
				: pfdm_pkg::MUL_W'(pfdm_pkg::DUTY_FULL);
		end else if (state_q == pfdm_pkg::ST_MUL && mplier_q != '0) begin
			if (mplier_q[0]) acc_q <= acc_q + mcand_q;
			mcand_q <= {mcand_q[pfdm_pkg::DEN_W-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[pfdm_pkg::MUL_W-1:1]};
		end
	end

	pfdm_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.num(div_num),
		.den(div_den),
		.stat(div_stat),
		.quo(div_quo)
	);

	// Output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == pfdm_pkg::ST_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == pfdm_pkg::ST_FIN && out_free) begin
			out_data_q <= {7'd0, duty_q, freq_q, count_q};
			out_user_q <= {sat_q, (period_q == '0)};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;
	assign m_tuser = out_user_q;

endmodule
`default_nettype wire
